// ===== rtl/core/speck_fp_pkg.sv =====
package speck_fp_pkg;

	localparam int unsigned HALF_W = 16;
	localparam int unsigned FP_W = 2 * HALF_W;
	localparam int unsigned ROUNDS_W = 6;
	localparam logic [ROUNDS_W-1:0] FINAL_ROUNDS_RESET = 6'd22;

	localparam int unsigned ROT_HI = 7;
	localparam int unsigned ROT_LO = 2;

	typedef struct packed {
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
	} chain_t;

	// one speck32 round with the message word as key
	function automatic chain_t mix_round(input chain_t c, input logic [HALF_W-1:0] key);
		chain_t r;
		logic [HALF_W-1:0] hi_rot;
		logic [HALF_W-1:0] lo_rot;
		hi_rot = {c.hi[ROT_HI-1:0], c.hi[HALF_W-1:ROT_HI]};
		lo_rot = {c.lo[HALF_W-ROT_LO-1:0], c.lo[HALF_W-1:HALF_W-ROT_LO]};
		r.hi = (hi_rot + c.lo) ^ key;
		r.lo = lo_rot ^ r.hi;
		return r;
	endfunction

endpackage

// ===== rtl/core/speck_round_fingerprint_hash.sv =====
// 32-bit fingerprint built from the speck32 round.
// input channel: data_word, byte_only, last_word under in_valid / in_stall;
// a word is taken when in_valid is high and in_stall is low.
// output channel: fingerprint under out_valid / out_stall, one word per message.
// cfg_wr_en / cfg_wr_data set the number of zero-key final rounds (reset 22);
// write it only while the block is idle.
// a word that is not the last one is absorbed in the cycle it is taken,
// so such words go at one per cycle.
// a last word is absorbed, then one shared round unit runs final_rounds more
// rounds, one per cycle, while in_stall is high; then the output register is
// loaded once it is free. out_valid rises with that load, and the next word
// is taken the cycle after that load.
// the output register sits apart from the round unit, so words keep flowing
// while a fingerprint waits; a finished fingerprint holds in the round unit
// if the previous one is still stalled, and in_stall stays high meanwhile.
// reset clears the chain, empties the output register and restores 22 rounds.
module speck_round_fingerprint_hash
	import speck_fp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [ROUNDS_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [HALF_W-1:0]   data_word,
	input  logic                byte_only,
	input  logic                last_word,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [FP_W-1:0]     fingerprint
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FIN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	chain_t              chain_q;
	chain_t              round_out;
	logic [HALF_W-1:0]   round_key;
	logic [ROUNDS_W-1:0] final_rounds_q;
	logic [ROUNDS_W-1:0] cnt_q;
	logic [FP_W-1:0]     fp_q;
	logic                out_valid_q;
	logic                take;
	logic                out_free;

	assign take     = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// shared round unit: message key while idle, zero key while finishing
	always_comb begin
		round_key = '0;
		if (state_q == ST_IDLE) begin
			round_key = byte_only ? {{(HALF_W-8){1'b0}}, data_word[7:0]} : data_word;
		end
		round_out = mix_round(chain_q, round_key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_rounds_q <= FINAL_ROUNDS_RESET;
		end else if (cfg_wr_en) begin
			final_rounds_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chain_q <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						chain_q <= round_out;
						if (last_word) begin
							cnt_q   <= final_rounds_q;
							state_q <= (final_rounds_q == '0) ? ST_EMIT : ST_FIN;
						end
					end
				end
				ST_FIN: begin
					chain_q <= round_out;
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == ROUNDS_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						chain_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a new word may replace the one leaving in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			fp_q <= {chain_q.hi, chain_q.lo};
		end
	end

	assign out_valid   = out_valid_q;
	assign fingerprint = fp_q;

endmodule

// ===== rtl/core/speck_fp_checker.sv =====
module speck_fp_checker
	import speck_fp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              last_word,
	input logic              out_valid,
	input logic              out_stall,
	input logic [FP_W-1:0]   fingerprint
);

	// a stalled fingerprint word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fingerprint))
		else $error("fingerprint dropped or changed under stall");

	// finishing a message always takes the block busy
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_word |=> in_stall)
		else $error("not busy after last word");

	// middle words leave the block free to take the next word
	a_mid_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_word |=> !in_stall)
		else $error("busy after a middle word");

	// a new fingerprint only comes out of a busy phase
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("fingerprint without finalisation");

endmodule

bind speck_round_fingerprint_hash speck_fp_checker u_speck_fp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.last_word   (last_word),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.fingerprint (fingerprint)
);

// ===== test/fingerprint_checker.sv =====
module fingerprint_checker
	import speck_fp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [ROUNDS_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [HALF_W-1:0]   data_word,
	input  logic                byte_only,
	input  logic                last_word,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [FP_W-1:0]     fingerprint,
	output int                  n_pending,
	output int                  n_mismatch
);
	timeunit 1ns;
	timeprecision 1ps;

	chain_t              chain = '0;
	logic [ROUNDS_W-1:0] rounds = FINAL_ROUNDS_RESET;
	logic [FP_W-1:0]     awaited_fp[$];
	int                  errors = 0;

	function automatic chain_t speck_mix(input chain_t c, input logic [HALF_W-1:0] key);
		chain_t n;
		n.hi = ({c.hi[6:0], c.hi[15:7]} + c.lo) ^ key;
		n.lo = {c.lo[13:0], c.lo[15:14]} ^ n.hi;
		return n;
	endfunction

	task automatic absorb(input logic [HALF_W-1:0] word, input logic byte_flag,
			input logic last_flag);
		logic [HALF_W-1:0] key;
		key = byte_flag ? {8'h00, word[7:0]} : word;
		chain = speck_mix(chain, key);
		if (last_flag) begin
			for (int i = 0; i < int'(rounds); i++)
				chain = speck_mix(chain, '0);
			awaited_fp.push_back({chain.hi, chain.lo});
			chain = '0;
		end
	endtask

	task automatic compare_fp(input logic [FP_W-1:0] got);
		logic [FP_W-1:0] want;
		if (awaited_fp.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: fingerprint %h arrived with no message outstanding",
					$realtime, got);
		end else begin
			want = awaited_fp.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("%0t: fingerprint expected %h got %h", $realtime, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain = '0;
			rounds = FINAL_ROUNDS_RESET;
			awaited_fp.delete();
			n_pending <= 0;
		end else begin
			if (cfg_wr_en)
				rounds = cfg_wr_data;
			// an output word always belongs to an earlier message, so check first
			if (out_valid && !out_stall)
				compare_fp(fingerprint);
			if (in_valid && !in_stall)
				absorb(data_word, byte_only, last_word);
			n_pending <= awaited_fp.size();
			n_mismatch <= errors;
		end
	end

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import speck_fp_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int SEG_WORDS = 88;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [ROUNDS_W-1:0] cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [HALF_W-1:0]   data_word = '0;
	logic                byte_only = 1'b0;
	logic                last_word = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FP_W-1:0]     fingerprint;

	int n_pending;
	int n_mismatch;
	int idle_pct = 24;
	int stall_pct = 64;
	int words_sent = 0;
	int cycle_cnt = 0;

	speck_round_fingerprint_hash u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_word   (data_word),
		.byte_only   (byte_only),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fingerprint (fingerprint)
	);

	fingerprint_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_word   (data_word),
		.byte_only   (byte_only),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fingerprint (fingerprint),
		.n_pending   (n_pending),
		.n_mismatch  (n_mismatch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_word(input logic [HALF_W-1:0] word, input logic byte_flag,
			input logic last_flag);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_word <= word;
		byte_only <= byte_flag;
		last_word <= last_flag;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_message();
		int len;
		logic [HALF_W-1:0] word;
		len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(7))
				0: word = '0;
				1: word = '1;
				default: word = HALF_W'($urandom);
			endcase
			send_word(word, $urandom_range(3) == 0, i == len - 1);
		end
	endtask

	// wait until every fingerprint is out and the round unit has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_final_rounds(input logic [ROUNDS_W-1:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int seg_target;
		logic [ROUNDS_W-1:0] setting;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-word messages from a clear chain, reset round count
		send_word(16'h0000, 1'b0, 1'b1);
		send_word(16'hffff, 1'b0, 1'b1);
		send_word(16'hffff, 1'b1, 1'b1);
		send_word(16'h00ff, 1'b1, 1'b1);
		// byte flag on words that are not the last
		send_word(16'h0001, 1'b0, 1'b0);
		send_word(16'h8000, 1'b0, 1'b0);
		send_word(16'haaaa, 1'b1, 1'b0);
		send_word(16'h5555, 1'b0, 1'b1);
		send_word(16'hffff, 1'b0, 1'b0);
		send_word(16'hffff, 1'b0, 1'b0);
		send_word(16'hff00, 1'b1, 1'b0);
		send_word(16'hffff, 1'b1, 1'b1);
		// back-to-back last words so a fingerprint waits behind a stalled one
		send_word(16'h1234, 1'b0, 1'b1);
		send_word(16'h8001, 1'b0, 1'b1);
		send_word(16'h7ffe, 1'b1, 1'b1);

		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: setting = '0;
				1: setting = '1;
				2: setting = 6'd1;
				3: setting = ROUNDS_W'($urandom_range(2, 62));
				4: setting = FINAL_ROUNDS_RESET;
				default: setting = '1;
			endcase
			set_final_rounds(setting);
			idle_pct  = (seg < 2) ? 24 : (seg < 4) ? 64 : 0;
			stall_pct = (seg < 2) ? 64 : (seg < 4) ? 24 : 0;
			seg_target = words_sent + SEG_WORDS;
			while (words_sent < seg_target)
				send_message();
		end

		wait_idle();
		if (n_mismatch == 0 && n_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
